// ----- hw/rtl/ptrm_pkg.sv -----
// shared constants and types for the prime test and root map block
`default_nettype none
package ptrm_pkg;

  localparam int VALUE_BITS    = 24;
  localparam int FRACTION_BITS = 16;
  localparam int OUT_BITS      = VALUE_BITS + FRACTION_BITS;
  localparam int ROOT_BITS     = (VALUE_BITS + 1) / 2 + FRACTION_BITS;
  localparam int RAD_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS      = ROOT_BITS + 1;
  localparam int CSUB_BITS     = ROOT_BITS + 3;
  localparam int DIV_BITS      = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS       = 2 * DIV_BITS;
  localparam int STEPS_MAX     = (VALUE_BITS > ROOT_BITS) ? VALUE_BITS : ROOT_BITS;
  localparam int CNT_BITS      = $clog2(STEPS_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DIV_END,
    ST_SQRT
  } state_t;

  typedef struct packed {
    logic                 ge;
    logic [CSUB_BITS-1:0] diff;
  } csub_res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ptrm_csub.sv -----
// shared compare and subtract unit for division and square root steps
`default_nettype none
module ptrm_csub (
  input  wire logic [ptrm_pkg::CSUB_BITS-1:0] a,
  input  wire logic [ptrm_pkg::CSUB_BITS-1:0] b,
  output ptrm_pkg::csub_res_t                 res
);
  import ptrm_pkg::*;

  logic [CSUB_BITS:0] sub;

  always_comb begin
    sub      = {1'b0, a} - {1'b0, b};
    res.ge   = ~sub[CSUB_BITS];
    res.diff = sub[CSUB_BITS-1:0];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/prime_test_root_map_core.sv -----
// top level: trial division prime test; the result is the fixed point square root of a prime, else the value itself
//
// command channel: value and last_item are taken at a clock edge where start
// is high and busy is low; for values of two or more busy then stays high until the transaction ends.
// result channel: result_value, is_prime and last_result are valid for exactly
// one cycle while done is high; the receiver cannot stall, and the ports hold
// their last values afterwards.
// sequence: values below two are answered straight from idle. otherwise each
// trial divisor d (2, 3, 4, ... while d*d <= value) runs the check state, the
// division steps through the shared compare and subtract unit, one quotient bit
// per cycle, and the division end state. a prime then runs the check state and
// the square root steps, one root bit per cycle.
// throughput: one transaction at a time; start is taken again in the cycle
// that done is high.
// reset: rst is synchronous and returns the sequencer to idle with done low.
`default_nettype none
module prime_test_root_map_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ptrm_pkg::VALUE_BITS-1:0]  value,
  input  wire logic                             last_item,
  output logic                                  done,
  output logic      [ptrm_pkg::OUT_BITS-1:0]    result_value,
  output logic                                  is_prime,
  output logic                                  last_result
);
  import ptrm_pkg::*;

  state_t                state, state_next;
  logic [VALUE_BITS-1:0] val, val_next;
  logic                  last_hold, last_hold_next;
  logic [DIV_BITS-1:0]   divisor, divisor_next;
  logic [SQ_BITS-1:0]    sq, sq_next;
  logic [REM_BITS-1:0]   rem, rem_next;
  logic [ROOT_BITS-1:0]  root, root_next;
  logic [RAD_BITS-1:0]   sh, sh_next;
  logic [CNT_BITS-1:0]   cnt, cnt_next;
  logic                  done_next;
  logic [OUT_BITS-1:0]   result_value_next;
  logic                  is_prime_next;
  logic                  last_result_next;
  logic [CSUB_BITS-1:0]  cs_a, cs_b;
  csub_res_t             cs;

  ptrm_csub u_csub (
    .a   (cs_a),
    .b   (cs_b),
    .res (cs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    val          <= val_next;
    last_hold    <= last_hold_next;
    divisor      <= divisor_next;
    sq           <= sq_next;
    rem          <= rem_next;
    root         <= root_next;
    sh           <= sh_next;
    cnt          <= cnt_next;
    result_value <= result_value_next;
    is_prime     <= is_prime_next;
    last_result  <= last_result_next;
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next        = state;
    val_next          = val;
    last_hold_next    = last_hold;
    divisor_next      = divisor;
    sq_next           = sq;
    rem_next          = rem;
    root_next         = root;
    sh_next           = sh;
    cnt_next          = cnt;
    done_next         = 1'b0;
    result_value_next = result_value;
    is_prime_next     = is_prime;
    last_result_next  = last_result;
    cs_a              = '0;
    cs_b              = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          val_next       = value;
          last_hold_next = last_item;
          divisor_next   = DIV_BITS'(2);
          sq_next        = SQ_BITS'(4);
          if (value < VALUE_BITS'(2)) begin
            done_next         = 1'b1;
            result_value_next = OUT_BITS'(value) << FRACTION_BITS;
            is_prime_next     = 1'b0;
            last_result_next  = last_item;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        rem_next = '0;
        if (sq <= SQ_BITS'(val)) begin
          sh_next    = RAD_BITS'(val) << (RAD_BITS - VALUE_BITS);
          cnt_next   = CNT_BITS'(VALUE_BITS - 1);
          state_next = ST_DIV;
        end else begin
          sh_next    = RAD_BITS'(val) << (2 * FRACTION_BITS);
          root_next  = '0;
          cnt_next   = CNT_BITS'(ROOT_BITS - 1);
          state_next = ST_SQRT;
        end
      end
      ST_DIV: begin
        cs_a     = CSUB_BITS'({rem, sh[RAD_BITS-1]});
        cs_b     = CSUB_BITS'(divisor);
        rem_next = cs.ge ? REM_BITS'(cs.diff) : REM_BITS'({rem, sh[RAD_BITS-1]});
        sh_next  = sh << 1;
        cnt_next = cnt - CNT_BITS'(1);
        if (cnt == '0) begin
          state_next = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        if (rem == '0) begin
          done_next         = 1'b1;
          result_value_next = OUT_BITS'(val) << FRACTION_BITS;
          is_prime_next     = 1'b0;
          last_result_next  = last_hold;
          state_next        = ST_IDLE;
        end else begin
          divisor_next = divisor + DIV_BITS'(1);
          sq_next      = sq + SQ_BITS'({divisor, 1'b1});
          state_next   = ST_CHECK;
        end
      end
      ST_SQRT: begin
        cs_a      = {rem, sh[RAD_BITS-1:RAD_BITS-2]};
        cs_b      = CSUB_BITS'({root, 2'b01});
        rem_next  = cs.ge ? REM_BITS'(cs.diff)
                          : REM_BITS'({rem, sh[RAD_BITS-1:RAD_BITS-2]});
        root_next = {root[ROOT_BITS-2:0], cs.ge};
        sh_next   = sh << 2;
        cnt_next  = cnt - CNT_BITS'(1);
        if (cnt == '0) begin
          done_next         = 1'b1;
          result_value_next = OUT_BITS'({root[ROOT_BITS-2:0], cs.ge});
          is_prime_next     = 1'b1;
          last_result_next  = last_hold;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && value >= VALUE_BITS'(2)) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    (done && !start) |=> !done)
    else $error("result strobe longer than one cycle");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (done && is_prime) |-> (result_value >> ROOT_BITS) == '0)
    else $error("square root result out of range");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_prime_test_root_map_core.sv -----
// testbench for the prime test and root map core: directed rows then random traffic
`default_nettype none
module tb_prime_test_root_map_core;

  localparam int VB = ptrm_pkg::VALUE_BITS;
  localparam int FB = ptrm_pkg::FRACTION_BITS;
  localparam int OB = ptrm_pkg::OUT_BITS;
  localparam int RB = ptrm_pkg::ROOT_BITS;
  localparam int STALL_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 100;
  localparam int ROW_COUNT = 15;

  typedef struct packed {
    logic [OB-1:0] root_or_value;
    logic          prime;
    logic          last;
  } map_t;

  typedef struct packed {
    logic [VB-1:0] value;
    logic          last_item;
    logic          typed;
    logic [OB-1:0] root_or_value;
    logic          prime;
  } row_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic [VB-1:0] value;
  logic          last_item;
  logic          done;
  logic [OB-1:0] result_value;
  logic          is_prime;
  logic          last_result;

  map_t pending_maps[$];
  map_t want;
  row_t directed_rows[ROW_COUNT];
  int   mismatches = 0;
  int   quiet_cycles = 0;

  prime_test_root_map_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .last_item    (last_item),
    .done         (done),
    .result_value (result_value),
    .is_prime     (is_prime),
    .last_result  (last_result)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic map_t predict_map(logic [VB-1:0] v, logic l);
    longint unsigned d;
    longint unsigned rad;
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    longint unsigned shifted;
    bit              prime;
    map_t            m;
    prime = (v >= 2);
    for (d = 2; prime && d * d <= v; d++) begin
      if (v % d == 0) prime = 1'b0;
    end
    root = 0;
    rem = 0;
    if (prime) begin
      rad = longint'(v) << (2 * FB);
      for (int k = RB - 1; k >= 0; k--) begin
        rem = (rem << 2) | ((rad >> (2 * k)) & 3);
        trial = (root << 2) | 1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 1;
        end else begin
          root = root << 1;
        end
      end
    end
    shifted = longint'(v) << FB;
    m.root_or_value = prime ? root[OB-1:0] : shifted[OB-1:0];
    m.prime = prime;
    m.last = l;
    return m;
  endfunction

  function automatic row_t make_row(logic [VB-1:0] v, logic l, logic typed,
                                    logic [OB-1:0] r, logic p);
    row_t row;
    row.value = v;
    row.last_item = l;
    row.typed = typed;
    row.root_or_value = r;
    row.prime = p;
    return row;
  endfunction

  task automatic send_item(input logic [VB-1:0] v, input logic l, input logic typed,
                           input map_t typed_map, input int idle_pct);
    map_t m;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    value <= v;
    last_item <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    m = typed ? typed_map : predict_map(v, l);
    pending_maps.push_back(m);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: result_value %h is_prime %b last_result %b",
                   result_value, is_prime, last_result);
      end else begin
        want = pending_maps.pop_front();
        if (want.root_or_value !== result_value || want.prime !== is_prime ||
            want.last !== last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b actual %h/%b/%b",
                     want.root_or_value, want.prime, want.last,
                     result_value, is_prime, last_result);
        end
      end
    end
  end

  // watchdog on cycles in which no command is taken and no result is given
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int            phase_idle[4];
    int            r;
    int            d;
    logic [VB-1:0] v;
    map_t          m;
    phase_idle = '{0, 61, 0, 11};
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    last_item = 1'b0;

    directed_rows[0]  = make_row(24'd0, 1'b0, 1'b1, 40'd0, 1'b0);
    directed_rows[1]  = make_row(24'd1, 1'b1, 1'b1, 40'd65536, 1'b0);
    directed_rows[2]  = make_row(24'd2, 1'b0, 1'b1, 40'd92681, 1'b1);
    directed_rows[3]  = make_row(24'd3, 1'b0, 1'b0, '0, 1'b0);
    directed_rows[4]  = make_row(24'd4, 1'b1, 1'b1, 40'd262144, 1'b0);
    directed_rows[5]  = make_row(24'd9, 1'b0, 1'b0, '0, 1'b0);
    directed_rows[6]  = make_row(24'd25, 1'b0, 1'b0, '0, 1'b0);
    directed_rows[7]  = make_row(24'd49, 1'b1, 1'b0, '0, 1'b0);
    directed_rows[8]  = make_row(24'd4093, 1'b0, 1'b0, '0, 1'b0);
    directed_rows[9]  = make_row(24'd65521, 1'b0, 1'b0, '0, 1'b0);
    directed_rows[10] = make_row(24'hFFFFFF, 1'b1, 1'b1, 40'hFFFFFF0000, 1'b0);
    directed_rows[11] = make_row(24'hFFFFFE, 1'b0, 1'b1, 40'hFFFFFE0000, 1'b0);
    directed_rows[12] = make_row(24'h800000, 1'b0, 1'b1, 40'h8000000000, 1'b0);
    directed_rows[13] = make_row(24'd16777213, 1'b1, 1'b0, '0, 1'b0);
    directed_rows[14] = make_row(24'd5, 1'b0, 1'b0, '0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      m.root_or_value = directed_rows[i].root_or_value;
      m.prime = directed_rows[i].prime;
      m.last = directed_rows[i].last_item;
      send_item(directed_rows[i].value, directed_rows[i].last_item,
                directed_rows[i].typed, m, 0);
    end

    m = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        v = VB'($urandom_range(4095));
      end else if (r < 75) begin
        v = VB'($urandom_range(65535));
      end else if (r < 87) begin
        // around squares, to exercise the divisor bound d*d <= value
        d = $urandom_range(255, 2);
        v = VB'(d * d + $urandom_range(2) - 1);
      end else begin
        // wide values kept composite with a small factor
        v = VB'($urandom);
        if ($urandom_range(1)) v[0] = 1'b0;
        else v = v - v % 3;
      end
      send_item(v, 1'($urandom_range(1)), 1'b0, m, phase_idle[n * 4 / RANDOM_ITEMS]);
    end
    start <= 1'b0;

    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
